// ===== src/char_scanline_dot_stretcher_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the character scanline dot stretcher
// Implication checks, clocked on the rising edge and held off during reset.
// ----------------------------------------------------------------------------
`ifndef CHAR_SCANLINE_DOT_STRETCHER_ASSERT_SVH
`define CHAR_SCANLINE_DOT_STRETCHER_ASSERT_SVH

// Same-cycle implication.
`define CSDS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("csds: same-cycle check failed");

// Next-cycle implication.
`define CSDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("csds: next-cycle check failed");

`endif

// ===== src/csds_pkg.sv =====
// ----------------------------------------------------------------------------
// csds_pkg
// Shared types and constants of the character scanline dot stretcher.
// ----------------------------------------------------------------------------
package csds_pkg;

    localparam int ROM_DEPTH_DEFAULT = 2048;
    localparam int ADDR_W            = 11;
    localparam int DATA_W            = 8;
    localparam int CODE_W            = 8;
    localparam int CHAR_W            = 7;   // code bits that pick the glyph
    localparam int REV_BIT           = 7;   // code bit for reverse video
    localparam int ROW_W             = 4;
    localparam int PIX_W             = 20;
    localparam int CNT_W             = 5;
    localparam int ROW_OFFSET        = 5;   // bottom half of double height
    localparam int LAST_ROW          = 15;  // row zero wraps to this row
    localparam int NARROW_DOTS       = 10;
    localparam int WIDE_DOTS         = 20;
    localparam int CMD_DEPTH         = 2;
    localparam int OUT_DEPTH         = 4;

    typedef enum logic [0:0] {
        MODE_LOAD   = 1'b0,
        MODE_RENDER = 1'b1
    } mode_t;

    typedef enum logic [1:0] {
        LT_DBL_BOTTOM = 2'd0,
        LT_DBL_TOP    = 2'd1,
        LT_DBL_WIDE   = 2'd2,
        LT_NORMAL     = 2'd3
    } line_type_t;

    // Classified item handed from front to back.
    typedef struct packed {
        logic              is_load;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic              inv;
        logic              wide;
        logic              first;
    } cmd_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixels;
        logic [CNT_W-1:0] count;
    } res_t;

endpackage

// ===== src/char_scanline_dot_stretcher.sv =====
// ----------------------------------------------------------------------------
// char_scanline_dot_stretcher
// Character ROM with scanline dot stretching, queue interfaces on both sides.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats arrive on push/full: a beat is taken when push is high and
//   full is low. mode selects a ROM load (rom_address, rom_data) or a render
//   (char_code, glyph_row, line_type, line_start). Loads give no result.
//   Each render gives one result beat on empty/pop: pixels and pixel_count
//   are valid while empty is low and the beat leaves when pop is high.
//   cfg_valid/cfg_ready write screen_reverse; cfg_ready is always high and
//   the register should be changed only while the block is idle.
//   Path: a render beat passes the command queue, the ROM read and the dot
//   stretch into the result queue. Throughput is one beat per cycle while
//   the result queue has room, set by the back end taking one command per
//   cycle, loads and reads in order.
//   Reset clears the queues, the carried dot and screen_reverse; the ROM is
//   not cleared and must be loaded before rows are rendered from it.
//   When the receiver stalls the result queue fills, the back end stops
//   issuing reads, the command queue fills and full rises.
// ----------------------------------------------------------------------------
module char_scanline_dot_stretcher #(
    parameter int ROM_DEPTH = csds_pkg::ROM_DEPTH_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // input queue
    input  logic                        push,
    output logic                        full,
    input  logic                        mode,
    input  logic [csds_pkg::ADDR_W-1:0] rom_address,
    input  logic [csds_pkg::DATA_W-1:0] rom_data,
    input  logic [csds_pkg::CODE_W-1:0] char_code,
    input  logic [csds_pkg::ROW_W-1:0]  glyph_row,
    input  logic [1:0]                  line_type,
    input  logic                        line_start,
    // configuration
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_data,
    // result queue
    output logic                        empty,
    input  logic                        pop,
    output logic [csds_pkg::PIX_W-1:0]  pixels,
    output logic [csds_pkg::CNT_W-1:0]  pixel_count
);

    localparam int CMD_W = $bits(csds_pkg::cmd_t);
    localparam int RES_W = $bits(csds_pkg::res_t);
    localparam int CCW   = $clog2(csds_pkg::CMD_DEPTH+1);
    localparam int OCW   = $clog2(csds_pkg::OUT_DEPTH+1);

    csds_pkg::cmd_t  front_cmd;
    csds_pkg::cmd_t  back_cmd;
    logic [CMD_W-1:0] cmd_dout;
    logic            cmd_empty;
    logic            cmd_pop;
    logic [CCW-1:0]  cmd_count;

    csds_pkg::res_t  back_res;
    csds_pkg::res_t  out_res;
    logic [RES_W-1:0] out_dout;
    logic            res_push;
    logic            out_full;
    logic [OCW-1:0]  out_count;

    // Classify the beat and map the row.
    csds_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .mode        (mode),
        .rom_address (rom_address),
        .rom_data    (rom_data),
        .char_code   (char_code),
        .glyph_row   (glyph_row),
        .line_type   (line_type),
        .line_start  (line_start),
        .cmd         (front_cmd)
    );

    // Decouple front and back; full is the queue's own flag.
    csds_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (csds_pkg::CMD_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (front_cmd),
        .full  (full),
        .pop   (cmd_pop),
        .dout  (cmd_dout),
        .empty (cmd_empty),
        .count (cmd_count)
    );

    assign back_cmd = csds_pkg::cmd_t'(cmd_dout);

    // Run ROM access and stretching in order.
    csds_back #(
        .ROM_DEPTH (ROM_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!cmd_empty),
        .cmd       (back_cmd),
        .cmd_pop   (cmd_pop),
        .out_count (out_count),
        .res_push  (res_push),
        .res       (back_res)
    );

    // Hold finished results until the receiver pops them.
    csds_fifo #(
        .WIDTH (RES_W),
        .DEPTH (csds_pkg::OUT_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (back_res),
        .full  (out_full),
        .pop   (pop),
        .dout  (out_dout),
        .empty (empty),
        .count (out_count)
    );

    assign out_res     = csds_pkg::res_t'(out_dout);
    assign pixels      = out_res.pixels;
    assign pixel_count = out_res.count;

    `include "char_scanline_dot_stretcher_assert.svh"

    `CSDS_ASSERT_IMP(a_no_push_full, clk, rst_n, res_push, !out_full)
    `CSDS_ASSERT_IMP(a_cmd_count_bound, clk, rst_n, cmd_pop, cmd_count != '0)
    `CSDS_ASSERT_NEXT(a_full_blocks, clk, rst_n, full && !cmd_pop, cmd_count == CCW'(csds_pkg::CMD_DEPTH))

endmodule

// ===== src/csds_ram.sv =====
// ----------------------------------------------------------------------------
// csds_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module csds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/csds_fifo.sv =====
// ----------------------------------------------------------------------------
// csds_fifo
// Small first-word-fall-through queue with an occupancy count.
// ----------------------------------------------------------------------------
module csds_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           din,
    output logic                       full,
    input  logic                       pop,
    output logic [WIDTH-1:0]           dout,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign dout    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH-1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH-1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ===== src/csds_front.sv =====
// ----------------------------------------------------------------------------
// csds_front
// Classify each input beat, map the glyph row and hold the reverse register.
// ----------------------------------------------------------------------------
module csds_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_data,
    input  logic                          mode,
    input  logic [csds_pkg::ADDR_W-1:0]   rom_address,
    input  logic [csds_pkg::DATA_W-1:0]   rom_data,
    input  logic [csds_pkg::CODE_W-1:0]   char_code,
    input  logic [csds_pkg::ROW_W-1:0]    glyph_row,
    input  logic [1:0]                    line_type,
    input  logic                          line_start,
    output csds_pkg::cmd_t                cmd
);

    logic                         screen_reverse_reg, screen_reverse_next;
    csds_pkg::line_type_t         lt;
    logic [csds_pkg::ROW_W-1:0]   row_sel;
    logic [csds_pkg::ROW_W-1:0]   rom_row;
    logic                         is_load;

    assign cfg_ready = 1'b1;
    assign lt        = csds_pkg::line_type_t'(line_type);
    assign is_load   = (csds_pkg::mode_t'(mode) == csds_pkg::MODE_LOAD);

    assign screen_reverse_next = (cfg_valid && cfg_ready) ? cfg_data : screen_reverse_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_reverse_reg <= 1'b0;
        end
        else
        begin
            screen_reverse_reg <= screen_reverse_next;
        end
    end

    // Halve the row for double height; the bottom half starts further down.
    always_comb
    begin
        unique case (lt)
            csds_pkg::LT_DBL_BOTTOM:
                row_sel = {1'b0, glyph_row[csds_pkg::ROW_W-1:1]}
                          + csds_pkg::ROW_W'(csds_pkg::ROW_OFFSET);
            csds_pkg::LT_DBL_TOP:
                row_sel = {1'b0, glyph_row[csds_pkg::ROW_W-1:1]};
            csds_pkg::LT_DBL_WIDE,
            csds_pkg::LT_NORMAL:
                row_sel = glyph_row;
        endcase
    end

    // Scanline zero shows the last ROM row; every other one sits a row up.
    assign rom_row = (row_sel == '0) ? csds_pkg::ROW_W'(csds_pkg::LAST_ROW)
                                     : row_sel - csds_pkg::ROW_W'(1);

    always_comb
    begin
        cmd.is_load = is_load;
        cmd.addr    = is_load ? rom_address
                              : {char_code[csds_pkg::CHAR_W-1:0], rom_row};
        cmd.data    = rom_data;
        cmd.inv     = screen_reverse_reg ^ char_code[csds_pkg::REV_BIT];
        cmd.wide    = (lt == csds_pkg::LT_DBL_WIDE);
        cmd.first   = line_start;
    end

endmodule

// ===== src/csds_back.sv =====
// ----------------------------------------------------------------------------
// csds_back
// Carry out queued commands: ROM writes, ROM reads and dot stretching.
// ----------------------------------------------------------------------------
`include "char_scanline_dot_stretcher_assert.svh"

module csds_back #(
    parameter int ROM_DEPTH = csds_pkg::ROM_DEPTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    input  csds_pkg::cmd_t                    cmd,
    output logic                              cmd_pop,
    input  logic [$clog2(csds_pkg::OUT_DEPTH+1)-1:0] out_count,
    output logic                              res_push,
    output csds_pkg::res_t                    res
);

    localparam int AW = $clog2(ROM_DEPTH);
    localparam int CW = $clog2(csds_pkg::OUT_DEPTH+1);
    localparam int DW = csds_pkg::DATA_W;

    logic [AW-1:0]  rom_addr;
    logic           addr_in_range;
    logic           room;
    logic [CW:0]    occupancy;
    logic           ram_we, ram_re;
    logic [DW-1:0]  glyph;

    logic           b_valid_reg, b_valid_next;
    logic           b_inv_reg, b_wide_reg, b_first_reg;
    logic           carried_reg, carried_next;

    logic [DW:0]    src;        // carried dot above the glyph, MSB first
    logic [DW-1:0]  stretched;
    logic [DW-1:0]  plain;
    logic           tail;

    // Reserve an output slot for every read in flight.
    assign occupancy = (CW+1)'(out_count) + (CW+1)'(b_valid_reg);
    assign room      = (occupancy < (CW+1)'(csds_pkg::OUT_DEPTH));
    assign cmd_pop   = cmd_valid && (cmd.is_load || room);

    assign rom_addr      = AW'(cmd.addr);
    assign addr_in_range = ({1'b0, rom_addr} < (AW+1)'(ROM_DEPTH));
    assign ram_we        = cmd_pop && cmd.is_load && addr_in_range;
    assign ram_re        = cmd_pop && !cmd.is_load;

    csds_ram #(
        .WIDTH (DW),
        .DEPTH (ROM_DEPTH)
    ) u_rom (
        .clk   (clk),
        .we    (ram_we),
        .waddr (rom_addr),
        .wdata (cmd.data),
        .re    (ram_re),
        .raddr (rom_addr),
        .rdata (glyph)
    );

    assign b_valid_next = ram_re;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            carried_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= b_valid_next;
            carried_reg <= carried_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_re)
        begin
            b_inv_reg   <= cmd.inv;
            b_wide_reg  <= cmd.wide;
            b_first_reg <= cmd.first;
        end
    end

    // Each lit dot also lights the next; the first dot looks at the carried one.
    assign src = {(b_first_reg ? 1'b0 : carried_reg), glyph};

    always_comb
    begin
        for (int b = 0; b < DW; b++)
        begin
            stretched[b] = (src[DW-1-b] | src[DW-b]) ^ b_inv_reg;
            plain[b]     = src[DW-1-b] ^ b_inv_reg;
        end
    end

    assign tail = glyph[0] ^ b_inv_reg;

    always_comb
    begin
        res.pixels = '0;
        if (b_wide_reg)
        begin
            for (int b = 0; b < DW; b++)
            begin
                res.pixels[2*b]   = stretched[b];
                res.pixels[2*b+1] = plain[b];
            end
            for (int b = 2*DW; b < csds_pkg::WIDE_DOTS; b++)
            begin
                res.pixels[b] = tail;
            end
            res.count = csds_pkg::CNT_W'(csds_pkg::WIDE_DOTS);
        end
        else
        begin
            res.pixels[DW-1:0] = stretched;
            for (int b = DW; b < csds_pkg::NARROW_DOTS; b++)
            begin
                res.pixels[b] = tail;
            end
            res.count = csds_pkg::CNT_W'(csds_pkg::NARROW_DOTS);
        end
    end

    assign res_push     = b_valid_reg;
    assign carried_next = b_valid_reg ? glyph[0] : carried_reg;

    `CSDS_ASSERT_IMP(a_out_no_overflow, clk, rst_n, b_valid_reg, out_count < CW'(csds_pkg::OUT_DEPTH))
    `CSDS_ASSERT_IMP(a_pop_only_valid, clk, rst_n, cmd_pop, cmd_valid)
    `CSDS_ASSERT_NEXT(a_carry_tracks_glyph, clk, rst_n, b_valid_reg, carried_reg == $past(glyph[0]))

endmodule
